// ===== design/hll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_pkg
// Shared types and constants for the header line lexer: byte classes,
// result tags, field limits and the queue entry format.
// ----------------------------------------------------------------------------
package hll_pkg;

  // Field and table limits.
  localparam logic [8:0] NAME_MAX  = 9'd64;
  localparam logic [8:0] VALUE_MAX = 9'd256;
  localparam logic [5:0] TABLE_MAX = 6'd32;

  // Characters with a special role.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Result tags.
  typedef enum logic [3:0] {
    TAG_NAME  = 4'd0,
    TAG_SKIP  = 4'd1,
    TAG_VALUE = 4'd2,
    TAG_HEND  = 4'd3,
    TAG_BEND  = 4'd4,
    TAG_BADN  = 4'd5,
    TAG_BADV  = 4'd6,
    TAG_LONGN = 4'd7,
    TAG_LONGV = 4'd8,
    TAG_IGN   = 4'd9,
    TAG_TRUNC = 4'd10
  } tag_t;

  // Character class of one byte, worked out by the front end.
  typedef struct packed {
    logic is_name;
    logic is_value;
    logic is_cr;
    logic is_colon;
  } char_class_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        last;
    char_class_t cls;
  } hll_item_t;

endpackage

// ===== design/hll_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_front
// Classifies an incoming byte into name, value, CR and colon classes and
// packs it with its framing flags into a queue entry.
// ----------------------------------------------------------------------------
module hll_front
  import hll_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       block_start,
  input  logic       last_byte,
  output hll_item_t  item
);

  logic is_lower;
  logic is_upper;
  logic is_digit;

  always_comb begin
    is_lower = (data_byte >= 8'h61) && (data_byte <= 8'h7A);
    is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
    is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);

    item.data         = data_byte;
    item.start        = block_start;
    item.last         = last_byte;
    item.cls.is_name  = is_lower || is_upper || is_digit ||
                        (data_byte == CH_DASH) || (data_byte == CH_UNDER);
    item.cls.is_value = (data_byte >= CH_SPACE) && (data_byte <= CH_TILDE);
    item.cls.is_cr    = (data_byte == CH_CR);
    item.cls.is_colon = (data_byte == CH_COLON);
  end

endmodule

// ===== design/hll_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_queue
// Two-entry queue of classified requests between the front end and the
// lexing back end.
// ----------------------------------------------------------------------------
module hll_queue
  import hll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hll_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output hll_item_t pop_item
);

  hll_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/hll_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_back
// Header line state machine: takes classified requests from the queue,
// tracks phase, field length and header count, and registers one tagged
// result per byte.
// ----------------------------------------------------------------------------
module hll_back
  import hll_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  hll_item_t  item,
  output logic       item_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] echo_byte,
  output logic [3:0] tag,
  output logic [8:0] field_pos,
  output logic [5:0] header_number,
  output logic       kept
);

  typedef enum logic [2:0] {
    PH_LINE  = 3'd0,
    PH_NAME  = 3'd1,
    PH_SEP   = 3'd2,
    PH_VALUE = 3'd3,
    PH_LSKIP = 3'd4,
    PH_BSKIP = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  phase_t     phase;
  logic [8:0] field_length;
  logic [5:0] header_count;
  logic       halted;

  phase_t     phase_next;
  logic [8:0] field_length_next;
  logic [5:0] header_count_next;
  logic       halted_next;

  phase_t     ph_cur;
  logic [8:0] fl_cur;
  logic [5:0] hc_cur;
  logic       hl_cur;
  logic       in_name;
  logic [8:0] name_len;
  logic       hdr;

  tag_t       tag_next;
  logic [8:0] pos_next;
  logic [5:0] hnum_next;
  logic       kept_next;

  logic       load;

  // A result is produced whenever a queued item waits and the output register is free or drains.
  assign load     = item_valid && (!out_valid || out_ready);
  assign item_pop = load;

  always_comb begin
    // A block start clears the state before the same byte is lexed.
    ph_cur = item.start ? PH_LINE : phase;
    fl_cur = item.start ? 9'd0 : field_length;
    hc_cur = item.start ? 6'd0 : header_count;
    hl_cur = item.start ? 1'b0 : halted;

    phase_next        = ph_cur;
    field_length_next = fl_cur;
    header_count_next = hc_cur;
    halted_next       = hl_cur;

    tag_next  = TAG_IGN;
    pos_next  = 9'd0;
    hnum_next = 6'd0;
    hdr       = 1'b0;

    // A non-CR byte at line start opens a name with an empty length.
    in_name  = ((ph_cur == PH_LINE) && !item.cls.is_cr) || (ph_cur == PH_NAME);
    name_len = (ph_cur == PH_LINE) ? 9'd0 : fl_cur;

    if (!hl_cur && (ph_cur != PH_DONE)) begin
      hnum_next = hc_cur;
      if (in_name) begin
        hdr               = 1'b1;
        phase_next        = PH_NAME;
        field_length_next = name_len;
        if (item.cls.is_colon) begin
          tag_next   = TAG_SKIP;
          phase_next = PH_SEP;
        end else if (!item.cls.is_name) begin
          tag_next    = TAG_BADN;
          pos_next    = name_len;
          halted_next = 1'b1;
        end else if (name_len >= NAME_MAX) begin
          tag_next    = TAG_LONGN;
          pos_next    = name_len;
          halted_next = 1'b1;
        end else begin
          tag_next          = TAG_NAME;
          pos_next          = name_len;
          field_length_next = name_len + 9'd1;
        end
      end else begin
        unique case (ph_cur)
          PH_LINE: begin
            tag_next   = TAG_BEND;
            phase_next = PH_BSKIP;
          end
          PH_SEP: begin
            hdr               = 1'b1;
            tag_next          = TAG_SKIP;
            phase_next        = PH_VALUE;
            field_length_next = 9'd0;
          end
          PH_VALUE: begin
            hdr = 1'b1;
            if (item.cls.is_cr) begin
              tag_next   = TAG_HEND;
              phase_next = PH_LSKIP;
            end else if (!item.cls.is_value) begin
              tag_next    = TAG_BADV;
              pos_next    = fl_cur;
              halted_next = 1'b1;
            end else if (fl_cur >= VALUE_MAX) begin
              tag_next    = TAG_LONGV;
              pos_next    = fl_cur;
              halted_next = 1'b1;
            end else begin
              tag_next          = TAG_VALUE;
              pos_next          = fl_cur;
              field_length_next = fl_cur + 9'd1;
            end
          end
          PH_LSKIP: begin
            hdr               = 1'b1;
            tag_next          = TAG_SKIP;
            phase_next        = PH_LINE;
            field_length_next = 9'd0;
            if (hc_cur < TABLE_MAX) begin
              header_count_next = hc_cur + 6'd1;
            end
          end
          PH_BSKIP: begin
            tag_next   = TAG_SKIP;
            phase_next = PH_DONE;
          end
          default: begin
            tag_next   = TAG_IGN;
            hnum_next  = 6'd0;
            phase_next = PH_DONE;
          end
        endcase
      end

      // The buffer ran out before the blank line was seen.
      if (item.last && (tag_next <= TAG_BEND) &&
          (phase_next != PH_BSKIP) && (phase_next != PH_DONE)) begin
        tag_next    = TAG_TRUNC;
        halted_next = 1'b1;
      end
    end

    kept_next = hdr && (hnum_next < TABLE_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE;
      field_length <= 9'd0;
      header_count <= 6'd0;
      halted       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        phase         <= phase_next;
        field_length  <= field_length_next;
        header_count  <= header_count_next;
        halted        <= halted_next;
        out_valid     <= 1'b1;
        echo_byte     <= item.data;
        tag           <= tag_next;
        field_pos     <= pos_next;
        header_number <= hnum_next;
        kept          <= kept_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // Every error or truncation result leaves the lexer halted.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    load && (tag_next == TAG_BADN || tag_next == TAG_BADV ||
             tag_next == TAG_LONGN || tag_next == TAG_LONGV ||
             tag_next == TAG_TRUNC) |=> halted)
    else $error("lexer not halted after an error result");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    header_count <= TABLE_MAX)
    else $error("header count exceeds table capacity");

  a_kept_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && kept |-> header_number < TABLE_MAX)
    else $error("kept header lies beyond table capacity");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (tag == TAG_IGN) |-> !kept && (header_number == 6'd0) &&
                                       (field_pos == 9'd0))
    else $error("ignored byte carries header information");
`endif

endmodule

// ===== design/header_line_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_line_lexer
// Byte-serial lexer for a header block: tags each byte as name, separator,
// value, header end, block end, error, ignored or truncated.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | data_byte, block_start, last_byte
//  out     | out_valid / out_ready| echo_byte, tag, field_pos, header_number,
//          |                      | kept
//
// One byte per clock sustained while out_ready holds; a byte taken is held in the
// queue and is then loaded into the output register, from which its result is
// accepted.
// The two-entry queue keeps the input open while a result waits, so in_ready
// drops only after two more bytes have piled up behind a stalled output.
// Synchronous reset empties the queue and returns the lexer to line start.
// ----------------------------------------------------------------------------
module header_line_lexer
  import hll_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       block_start,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] echo_byte,
  output logic [3:0] tag,
  output logic [8:0] field_pos,
  output logic [5:0] header_number,
  output logic       kept
);

  hll_item_t front_item;
  hll_item_t queue_item;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;
  logic      push;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  hll_front u_front (
    .data_byte   (data_byte),
    .block_start (block_start),
    .last_byte   (last_byte),
    .item        (front_item)
  );

  hll_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_valid),
    .pop_item  (queue_item)
  );

  hll_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (queue_valid),
    .item          (queue_item),
    .item_pop      (queue_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .echo_byte     (echo_byte),
    .tag           (tag),
    .field_pos     (field_pos),
    .header_number (header_number),
    .kept          (kept)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for header_line_lexer. A short table of directed
// requests covers the block ends, separators, character limits, errors and
// truncation, then random header blocks follow, mostly well formed with
// random content and some corruption. Every result is checked field by
// field against the literals of a typed row or else a byte-level lexer model.
// ----------------------------------------------------------------------------
module tb
  import hll_pkg::*;
;

  localparam int CLK_HALF     = 6;
  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_TAIL   = 150;
  localparam int LONG_HOLD    = 80;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [2:0] {
    LX_LINE, LX_NAME, LX_SEP, LX_VALUE, LX_LSKIP, LX_BSKIP, LX_DONE
  } lex_phase_t;

  typedef struct packed {
    logic [7:0] echo;
    tag_t       tag;
    logic [8:0] pos;
    logic [5:0] hnum;
    logic       kept;
  } lex_result_t;

  // One request; typed rows carry their expected result as literals.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
    logic       typed;
    tag_t       tag;
    logic [8:0] pos;
    logic [5:0] hnum;
    logic       kept;
  } lex_row_t;

  localparam lex_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h0D, 1'b1, 1'b0, 1'b1, TAG_BEND,  9'd0, 6'd0, 1'b0},
    '{8'h0A, 1'b0, 1'b0, 1'b1, TAG_SKIP,  9'd0, 6'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b1, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h3A, 1'b1, 1'b0, 1'b1, TAG_SKIP,  9'd0, 6'd0, 1'b1},
    '{8'h00, 1'b0, 1'b0, 1'b1, TAG_SKIP,  9'd0, 6'd0, 1'b1},
    '{8'h20, 1'b0, 1'b0, 1'b1, TAG_VALUE, 9'd0, 6'd0, 1'b1},
    '{8'h7E, 1'b0, 1'b0, 1'b1, TAG_VALUE, 9'd1, 6'd0, 1'b1},
    '{8'h0D, 1'b0, 1'b0, 1'b1, TAG_HEND,  9'd0, 6'd0, 1'b1},
    '{8'hFF, 1'b0, 1'b0, 1'b1, TAG_SKIP,  9'd0, 6'd0, 1'b1},
    '{8'h7A, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h30, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h39, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h2D, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h5F, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h3A, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h20, 1'b0, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h7F, 1'b0, 1'b0, 1'b1, TAG_BADV,  9'd0, 6'd1, 1'b1},
    '{8'h61, 1'b0, 1'b0, 1'b1, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b1, TAG_BADN,  9'd0, 6'd0, 1'b1},
    '{8'h5A, 1'b1, 1'b1, 1'b1, TAG_TRUNC, 9'd0, 6'd0, 1'b1},
    '{8'h62, 1'b0, 1'b0, 1'b1, TAG_IGN,   9'd0, 6'd0, 1'b0},
    '{8'h0D, 1'b1, 1'b1, 1'b1, TAG_BEND,  9'd0, 6'd0, 1'b0},
    '{8'h0A, 1'b0, 1'b1, 1'b1, TAG_SKIP,  9'd0, 6'd0, 1'b0},
    '{8'h2F, 1'b1, 1'b0, 1'b0, TAG_IGN,   9'd0, 6'd0, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       block_start = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] echo_byte;
  logic [3:0] tag;
  logic [8:0] field_pos;
  logic [5:0] header_number;
  logic       kept;

  header_line_lexer dut (
    .clk, .rst,
    .in_valid, .in_ready, .data_byte, .block_start, .last_byte,
    .out_valid, .out_ready, .echo_byte, .tag, .field_pos, .header_number, .kept
  );

  always #(CLK_HALF) clk = ~clk;

  // Lexer state as the bench tracks it.
  lex_phase_t lx_phase = LX_LINE;
  logic [8:0] lx_len = '0;
  logic [5:0] lx_hdrs = '0;
  logic       lx_halted = 1'b0;

  lex_row_t    request_q [$];
  lex_result_t expected_results [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          tail_start = 0;

  function automatic bit is_name_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic lex_result_t lex_byte(input logic [7:0] c, input logic start,
                                           input logic last);
    lex_result_t r;
    bit in_header;
    r = '{echo: c, tag: TAG_IGN, pos: '0, hnum: '0, kept: 1'b0};
    in_header = 1'b0;
    if (start) begin
      lx_phase = LX_LINE;
      lx_len = '0;
      lx_hdrs = '0;
      lx_halted = 1'b0;
    end
    if (!lx_halted && lx_phase != LX_DONE) begin
      r.hnum = lx_hdrs;
      case (lx_phase)
        LX_LINE, LX_NAME: begin
          if (lx_phase == LX_LINE && c == CH_CR) begin
            r.tag = TAG_BEND;
            lx_phase = LX_BSKIP;
          end else begin
            if (lx_phase == LX_LINE) begin
              lx_phase = LX_NAME;
              lx_len = '0;
            end
            in_header = 1'b1;
            if (c == CH_COLON) begin
              r.tag = TAG_SKIP;
              lx_phase = LX_SEP;
            end else if (!is_name_char(c)) begin
              r.tag = TAG_BADN;
              r.pos = lx_len;
              lx_halted = 1'b1;
            end else if (lx_len >= NAME_MAX) begin
              r.tag = TAG_LONGN;
              r.pos = lx_len;
              lx_halted = 1'b1;
            end else begin
              r.tag = TAG_NAME;
              r.pos = lx_len;
              lx_len = lx_len + 1'b1;
            end
          end
        end
        LX_SEP: begin
          in_header = 1'b1;
          r.tag = TAG_SKIP;
          lx_phase = LX_VALUE;
          lx_len = '0;
        end
        LX_VALUE: begin
          in_header = 1'b1;
          if (c == CH_CR) begin
            r.tag = TAG_HEND;
            lx_phase = LX_LSKIP;
          end else if (c < CH_SPACE || c > CH_TILDE) begin
            r.tag = TAG_BADV;
            r.pos = lx_len;
            lx_halted = 1'b1;
          end else if (lx_len >= VALUE_MAX) begin
            r.tag = TAG_LONGV;
            r.pos = lx_len;
            lx_halted = 1'b1;
          end else begin
            r.tag = TAG_VALUE;
            r.pos = lx_len;
            lx_len = lx_len + 1'b1;
          end
        end
        LX_LSKIP: begin
          in_header = 1'b1;
          r.tag = TAG_SKIP;
          lx_phase = LX_LINE;
          lx_len = '0;
          if (lx_hdrs < TABLE_MAX) lx_hdrs = lx_hdrs + 1'b1;
        end
        LX_BSKIP: begin
          r.tag = TAG_SKIP;
          lx_phase = LX_DONE;
        end
        default: begin
          r.tag = TAG_IGN;
          r.hnum = '0;
          lx_phase = LX_DONE;
        end
      endcase
      if (in_header && r.hnum < TABLE_MAX) r.kept = 1'b1;
      // A request marked last cuts the block short unless the blank line was seen.
      if (last && r.tag <= TAG_BEND && lx_phase != LX_BSKIP && lx_phase != LX_DONE) begin
        r.tag = TAG_TRUNC;
        lx_halted = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    request_q.push_back('{data: c, start: 1'b0, last: 1'b0, typed: 1'b0,
                          tag: TAG_IGN, pos: '0, hnum: '0, kept: 1'b0});
  endfunction

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? CH_DASH : CH_UNDER;
  endfunction

  function automatic logic [7:0] skip_byte(input logic [7:0] usual);
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : usual;
  endfunction

  // Appends one header block. A tidy block (saturation run or one long value)
  // always starts cleanly, ends with the blank line and carries no corruption.
  function automatic void add_block(input int n_hdrs, input bit tiny, input int long_hdr);
    int  first, hdr_first, nlen, vlen;
    bit  tidy;
    first = request_q.size();
    tidy = tiny || long_hdr >= 0;
    for (int h = 0; h < n_hdrs; h++) begin
      hdr_first = request_q.size();
      if (tiny) nlen = 1;
      else if (!tidy && $urandom_range(0, 11) == 0)
        nlen = $urandom_range(NAME_MAX - 1, NAME_MAX + 1);
      else nlen = $urandom_range(0, 8);
      if (tiny) vlen = 0;
      else if (h == long_hdr) vlen = VALUE_MAX + 1;
      else vlen = $urandom_range(0, 12);
      for (int k = 0; k < nlen; k++) add_byte(rand_name_char());
      add_byte(CH_COLON);
      add_byte(skip_byte(CH_SPACE));
      for (int k = 0; k < vlen; k++) add_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
      add_byte(CH_CR);
      add_byte(skip_byte(8'h0A));
      if (!tidy && $urandom_range(0, 9) == 0)
        request_q[$urandom_range(hdr_first, request_q.size() - 1)].data =
          8'($urandom_range(0, 255));
    end
    if (tidy || $urandom_range(0, 7) != 0) begin
      add_byte(CH_CR);
      add_byte(8'h0A);
      if (!tidy && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    end
    // A block with no headers and no blank line adds nothing to mark.
    if (request_q.size() == first) return;
    if (tidy || $urandom_range(0, 11) != 0) request_q[first].start = 1'b1;
    if (!tidy) begin
      case ($urandom_range(0, 5))
        0: request_q[$urandom_range(first, request_q.size() - 1)].last = 1'b1;
        1, 2: request_q[request_q.size() - 1].last = 1'b1;
        default: ;
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  // Drives one request and waits for it to be taken.
  task automatic offer(input lex_row_t row);
    lex_result_t predicted;
    in_valid    <= 1'b1;
    data_byte   <= row.data;
    block_start <= row.start;
    last_byte   <= row.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = lex_byte(row.data, row.start, row.last);
    if (row.typed)
      expected_results.push_back('{echo: row.data, tag: row.tag, pos: row.pos,
                                   hnum: row.hnum, kept: row.kept});
    else
      expected_results.push_back(predicted);
    @(negedge clk);
  endtask

  initial begin : source
    int blk;
    for (int i = 0; i < N_DIRECTED; i++) request_q.push_back(DIRECTED_ROWS[i]);
    blk = 0;
    while (request_q.size() < N_DIRECTED + RANDOM_ITEMS) begin
      case (blk)
        1: add_block(TABLE_MAX + 3, 1'b1, -1);
        3: add_block(2, 1'b0, 0);
        default: add_block($urandom_range(0, 6), 1'b0, -1);
      endcase
      blk++;
    end
    tail_start = request_q.size() - QUIET_TAIL;

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < request_q.size(); i++) begin
      if (i == N_DIRECTED) begin
        // Let the block drain completely before the random part.
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
      end else if (i < tail_start && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      offer(request_q[i]);
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : sink
    bit held_long;
    held_long = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_long && results_seen >= N_DIRECTED + 100) begin
        // Long hold-off so the queue fills and in_ready drops.
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (results_seen < tail_start && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lex_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, echo_byte %02h tag %0d",
                                  echo_byte, tag));
      end else begin
        want = expected_results.pop_front();
        if (echo_byte !== want.echo)
          report_mismatch($sformatf("echo_byte %02h, want %02h", echo_byte, want.echo));
        if (tag !== want.tag)
          report_mismatch($sformatf("tag %0d, want %0d (byte %02h)", tag, want.tag,
                                    want.echo));
        if (field_pos !== want.pos)
          report_mismatch($sformatf("field_pos %0d, want %0d", field_pos, want.pos));
        if (header_number !== want.hnum)
          report_mismatch($sformatf("header_number %0d, want %0d", header_number,
                                    want.hnum));
        if (kept !== want.kept)
          report_mismatch($sformatf("kept %0b, want %0b", kept, want.kept));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/hll_pkg.sv
design/hll_front.sv
design/hll_queue.sv
design/hll_back.sv
design/header_line_lexer.sv
tb/tb.sv
